/* rtl/core/qdd_pkg.sv */
// Shared types and constants for the quadrature detent decoder.
`timescale 1ns / 1ps

package qdd_pkg;

    localparam int POS_W    = 32;
    localparam int WIN_W    = 16;
    localparam int STEP_W   = 8;
    localparam int EVENT_W  = 2;
    localparam int INDEX_W  = 3;
    localparam int CFG_W    = 16;

    // Decoder phases: idle at 11, then the last level seen on the way round.
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_01   = 2'd1;
    localparam logic [1:0] PH_00   = 2'd2;
    localparam logic [1:0] PH_10   = 2'd3;

    // Result step event codes.
    localparam logic [EVENT_W-1:0] EV_NONE = 2'd0;
    localparam logic [EVENT_W-1:0] EV_UP   = 2'd1;
    localparam logic [EVENT_W-1:0] EV_DOWN = 2'd2;

    // Input command codes.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // Configuration register indexes.
    localparam logic [INDEX_W-1:0] REG_WINDOW_RELOAD  = 3'd0;
    localparam logic [INDEX_W-1:0] REG_MID_THRESHOLD  = 3'd1;
    localparam logic [INDEX_W-1:0] REG_FAST_THRESHOLD = 3'd2;
    localparam logic [INDEX_W-1:0] REG_MID_STEP       = 3'd3;
    localparam logic [INDEX_W-1:0] REG_FAST_STEP      = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [WIN_W-1:0]  RST_WINDOW_RELOAD  = 16'd1000;
    localparam logic [WIN_W-1:0]  RST_MID_THRESHOLD  = 16'd500;
    localparam logic [WIN_W-1:0]  RST_FAST_THRESHOLD = 16'd800;
    localparam logic [STEP_W-1:0] RST_MID_STEP       = 8'd2;
    localparam logic [STEP_W-1:0] RST_FAST_STEP      = 8'd4;

    typedef struct packed {
        logic [WIN_W-1:0]  window_reload;
        logic [WIN_W-1:0]  mid_threshold;
        logic [WIN_W-1:0]  fast_threshold;
        logic [STEP_W-1:0] mid_step;
        logic [STEP_W-1:0] fast_step;
    } cfg_t;

endpackage

/* rtl/core/qdd_if.sv */
// Valid/ready channel interfaces for encoder items and decoder results.
`timescale 1ns / 1ps

interface qdd_in_if;
    logic valid;
    logic ready;
    logic command;
    logic level_a;
    logic level_b;

    modport source (output valid, output command, output level_a, output level_b,
                    input ready);
    modport sink   (input valid, input command, input level_a, input level_b,
                    output ready);
endinterface

interface qdd_out_if;
    logic                       valid;
    logic                       ready;
    logic [qdd_pkg::POS_W-1:0]   position;
    logic [qdd_pkg::EVENT_W-1:0] step_event;

    modport source (output valid, output position, output step_event, input ready);
    modport sink   (input valid, input position, input step_event, output ready);
endinterface

/* rtl/core/qdd_cfg.sv */
// Configuration register file of the quadrature detent decoder.
`timescale 1ns / 1ps

module qdd_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        write_en,
    input  logic [qdd_pkg::INDEX_W-1:0] reg_index,
    input  logic [qdd_pkg::CFG_W-1:0]   write_data,
    output qdd_pkg::cfg_t               cfg
);
    import qdd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_en)
        begin
            unique case (reg_index)
                REG_WINDOW_RELOAD:  cfg_next.window_reload  = write_data;
                REG_MID_THRESHOLD:  cfg_next.mid_threshold  = write_data;
                REG_FAST_THRESHOLD: cfg_next.fast_threshold = write_data;
                REG_MID_STEP:       cfg_next.mid_step       = write_data[STEP_W-1:0];
                REG_FAST_STEP:      cfg_next.fast_step      = write_data[STEP_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_reload  <= RST_WINDOW_RELOAD;
            cfg_reg.mid_threshold  <= RST_MID_THRESHOLD;
            cfg_reg.fast_threshold <= RST_FAST_THRESHOLD;
            cfg_reg.mid_step       <= RST_MID_STEP;
            cfg_reg.fast_step      <= RST_FAST_STEP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/core/qdd_core.sv */
// Detent state machine, speed window and position counter with result register.
`timescale 1ns / 1ps

module qdd_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  qdd_pkg::cfg_t                cfg,
    input  logic                         accept,
    input  logic                         command,
    input  logic                         level_a,
    input  logic                         level_b,
    output logic [qdd_pkg::POS_W-1:0]    position,
    output logic [qdd_pkg::EVENT_W-1:0]  step_event
);
    import qdd_pkg::*;

    logic [1:0]         phase_reg,    phase_next;
    logic [WIN_W-1:0]   window_reg,   window_next;
    logic [POS_W-1:0]   position_reg, position_next;
    logic [EVENT_W-1:0] event_reg,    event_next;
    logic [1:0]         levels;
    logic [STEP_W-1:0]  step;

    assign levels = {level_a, level_b};

    // Speed-dependent step size; the fast test has priority.
    always_comb
    begin
        if (window_reg >= cfg.fast_threshold)
            step = cfg.fast_step;
        else if (window_reg >= cfg.mid_threshold)
            step = cfg.mid_step;
        else
            step = STEP_W'(1);
    end

    always_comb
    begin
        phase_next    = phase_reg;
        window_next   = window_reg;
        position_next = position_reg;
        event_next    = EV_NONE;
        if (command == CMD_TICK)
        begin
            if (window_reg != '0)
                window_next = window_reg - WIN_W'(1);
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    window_next = cfg.window_reload;
                    if (levels == 2'b01)
                        phase_next = PH_01;
                    else if (levels == 2'b10)
                        phase_next = PH_10;
                end
                PH_01:
                begin
                    if (levels == 2'b00)
                        phase_next = PH_00;
                    else if (levels == 2'b11)
                    begin
                        phase_next    = PH_IDLE;
                        position_next = position_reg + POS_W'(step);
                        event_next    = EV_UP;
                    end
                end
                PH_00:
                begin
                    if (levels == 2'b10)
                        phase_next = PH_10;
                    else if (levels == 2'b01)
                        phase_next = PH_01;
                end
                PH_10:
                begin
                    if (levels == 2'b11)
                    begin
                        phase_next    = PH_IDLE;
                        position_next = position_reg - POS_W'(step);
                        event_next    = EV_DOWN;
                    end
                    else if (levels == 2'b00)
                        phase_next = PH_00;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            window_reg   <= '0;
            position_reg <= '0;
            event_reg    <= EV_NONE;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            window_reg   <= window_next;
            position_reg <= position_next;
            event_reg    <= event_next;
        end
    end

    assign position   = position_reg;
    assign step_event = event_reg;

endmodule

/* rtl/core/quadrature_detent_decoder_accel.sv */
// Top level of the quadrature rotary encoder detent decoder with acceleration.
`timescale 1ns / 1ps

// Each transfer on the items channel is either a sample of the encoder's A/B
// levels (command 0) or one timer tick (command 1), and it produces exactly one
// transfer on the results channel carrying the position count after that item
// and a step event (none, up or down). A detent is counted when the levels
// return to 11, coming from 01 (up) or from 10 (down). While the decoder rests
// at 11, every sample reloads a speed window from window_reload; timer ticks
// count that window down to zero. On a completed detent the remaining window
// selects fast_step, mid_step or a step of one, and the 32-bit position wraps.
// The decoder state and the result register update at the edge at which the
// item transfers, so the result is offered on the next cycle and a new item
// is taken every cycle as long as the result side keeps up. The single result
// register is the only buffering, so items stall only while an unread result
// is held. Configuration registers are written through
// write_en/reg_index/write_data and should change only while the block is
// idle; writes to unknown indexes are dropped.

module quadrature_detent_decoder_accel (
    input  logic                        clk,
    input  logic                        rst_n,
    qdd_in_if.sink                      items,
    qdd_out_if.source                   results,
    input  logic                        write_en,
    input  logic [qdd_pkg::INDEX_W-1:0] reg_index,
    input  logic [qdd_pkg::CFG_W-1:0]   write_data
);
    import qdd_pkg::*;

    cfg_t cfg;
    logic accept;
    logic out_valid_reg;
    logic out_valid_next;

    qdd_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .write_en   (write_en),
        .reg_index  (reg_index),
        .write_data (write_data),
        .cfg        (cfg)
    );

    // An item is taken whenever the result register is empty or its
    // contents are being transferred out in this same cycle.
    assign items.ready = !out_valid_reg || results.ready;
    assign accept      = items.valid && items.ready;

    qdd_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .accept     (accept),
        .command    (items.command),
        .level_a    (items.level_a),
        .level_b    (items.level_b),
        .position   (results.position),
        .step_event (results.step_event)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (results.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign results.valid = out_valid_reg;

endmodule

/* rtl/core/qdd_checker.sv */
// Port-level assertions for the quadrature detent decoder, bound to its top level.
`timescale 1ns / 1ps

module qdd_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic                         in_command,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [qdd_pkg::POS_W-1:0]    out_position,
    input  logic [qdd_pkg::EVENT_W-1:0]  out_step_event
);
    import qdd_pkg::*;

    // Every accepted item has its result on offer in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted item produced no result");

    // A timer tick never reports a detent.
    a_tick_no_event: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_command == CMD_TICK) |=> out_step_event == EV_NONE)
        else $error("timer tick reported a step event");

    // A held result keeps its position while stalled.
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_position))
        else $error("stalled result changed");

    // The step event code is never the unused value.
    a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_step_event == EV_NONE) || (out_step_event == EV_UP)
                      || (out_step_event == EV_DOWN))
        else $error("illegal step event code");

endmodule

bind quadrature_detent_decoder_accel qdd_checker u_qdd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (items.valid),
    .in_ready       (items.ready),
    .in_command     (items.command),
    .out_valid      (results.valid),
    .out_ready      (results.ready),
    .out_position   (results.position),
    .out_step_event (results.step_event)
);

/* tb/tb.sv */
// Self-checking testbench for the quadrature detent decoder with acceleration.
`timescale 1ns / 1ps

// The bench drives encoder samples and timer ticks into the decoder over the
// items channel and checks every transfer on the results channel against a
// predictor that tracks the detent phase, the speed window and the position.
// A short scripted run comes first. It covers the reset state, both rotation
// directions on short paths, the long path down, position wrap in both
// directions, the three step sizes, a step of zero, ticks that saturate the
// window at zero, thresholds given out of order and masking of register data.
// Random phases follow. Each one starts from a new register setting, and the
// first two settings are the extremes. The random items are mostly complete
// detent gestures with timer ticks mixed in, so that the remaining window
// lands on both sides of the thresholds. Bounces, runs of ticks and pure
// noise make up the rest. Both sides idle at random. One phase runs with no
// idling at all. In one phase the result side holds off for a long stretch
// while items keep coming, so the decoder fills up and stalls its input.
// Every phase also stops sending halfway until all results are back.

module tb;
    import qdd_pkg::*;

    localparam int IDLE_MAX      = 7;
    localparam int HOLD_CYCLES   = 64;
    localparam int BURST_ITEMS   = 30;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 205;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SCRIPT_ROWS   = 33;

    // Encoder levels as {A, B}.
    localparam logic [1:0] LV_00 = 2'b00;
    localparam logic [1:0] LV_01 = 2'b01;
    localparam logic [1:0] LV_10 = 2'b10;
    localparam logic [1:0] LV_11 = 2'b11;

    typedef enum logic { ROW_ITEM, ROW_WRITE } row_kind_t;

    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic [EVENT_W-1:0] step_event;
    } count_rec_t;

    // One line of the scripted run: either an item or a register write. The
    // expected result is given here only where it is obvious by inspection.
    // All other items take their expected result from the predictor.
    typedef struct {
        row_kind_t          kind;
        logic [INDEX_W-1:0] index;
        logic [CFG_W-1:0]   data;
        logic               command;
        logic [1:0]         levels;
        bit                 typed;
        count_rec_t         want;
    } script_row_t;

    logic               clk;
    logic               rst_n;
    logic               write_en;
    logic [INDEX_W-1:0] reg_index;
    logic [CFG_W-1:0]   write_data;

    qdd_in_if  items_ch ();
    qdd_out_if results_ch ();

    quadrature_detent_decoder_accel uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items_ch),
        .results    (results_ch),
        .write_en   (write_en),
        .reg_index  (reg_index),
        .write_data (write_data)
    );

    // Predictor state: a copy of the decoder's registers and configuration.
    cfg_t               dec_cfg;
    logic [1:0]         dec_phase;
    logic [WIN_W-1:0]   speed_window;
    logic [POS_W-1:0]   pos_count;

    // Results still owed by the decoder, oldest first.
    count_rec_t         awaited_counts [$];

    int  mismatches    = 0;
    int  items_sent    = 0;
    int  ticks_sent    = 0;
    int  ups_seen      = 0;
    int  downs_seen    = 0;
    int  writes_done   = 0;
    int  settings_used = 0;
    int  cycle_count   = 0;
    bit  no_idle       = 1'b0;
    bit  sender_calm   = 1'b0;
    bit  hold_request  = 1'b0;

    script_row_t script [0:SCRIPT_ROWS-1] = '{
        // Straight after reset the window is zero and the reset steps apply.
        '{ROW_ITEM, '0, '0, CMD_TICK,   LV_11, 1'b1, '{32'd0, EV_NONE}},
        '{ROW_ITEM, '0, '0, CMD_SAMPLE, LV_11, 1'b1, '{32'd0, EV_NONE}},
        // Short path up: a full window of 1000 picks the fast step of 4.
        '{ROW_ITEM, '0, '0, CMD_SAMPLE, LV_01, 1'b0, '{32'd0, EV_NONE}},
        '{ROW_ITEM, '0, '0, CMD_SAMPLE, LV_11, 1'b1, '{32'd4, EV_UP}},
        // Long way round through 10, 00, 01, 00, 10 and back down to zero.
        '{ROW_ITEM, '0, '0, CMD_SAMPLE, LV_10, 1'b0, '{32'd0, EV_NONE}},
        '{ROW_ITEM, '0, '0, CMD_SAMPLE, LV_00, 1'b0, '{32'd0, EV_NONE}},
        '{ROW_ITEM, '0, '0, CMD_SAMPLE, LV_01, 1'b0, '{32'd0, EV_NONE}},
        '{ROW_ITEM, '0, '0, CMD_SAMPLE, LV_00, 1'b0, '{32'd0, EV_NONE}},
        '{ROW_ITEM, '0, '0, CMD_SAMPLE, LV_10, 1'b0, '{32'd0, EV_NONE}},
        '{ROW_ITEM, '0, '0, CMD_SAMPLE, LV_11, 1'b1, '{32'd0, EV_DOWN}},
        // Down from zero wraps the position.
        '{ROW_ITEM, '0, '0, CMD_SAMPLE, LV_11, 1'b0, '{32'd0, EV_NONE}},
        '{ROW_ITEM, '0, '0, CMD_SAMPLE, LV_10, 1'b0, '{32'd0, EV_NONE}},
        '{ROW_ITEM, '0, '0, CMD_SAMPLE, LV_11, 1'b1, '{32'hFFFF_FFFC, EV_DOWN}},
        // A stray 10 after 01 leaves the phase alone; the up count wraps back.
        '{ROW_ITEM, '0, '0, CMD_SAMPLE, LV_01, 1'b0, '{32'd0, EV_NONE}},
        '{ROW_ITEM, '0, '0, CMD_SAMPLE, LV_10, 1'b0, '{32'd0, EV_NONE}},
        '{ROW_ITEM, '0, '0, CMD_SAMPLE, LV_11, 1'b1, '{32'd0, EV_UP}},
        // Tiny window, fast threshold out of reach, zero mid step. The upper
        // byte of the step writes must be dropped.
        '{ROW_WRITE, REG_WINDOW_RELOAD,  16'd2,     CMD_SAMPLE, LV_00, 1'b0, '{32'd0, EV_NONE}},
        '{ROW_WRITE, REG_MID_THRESHOLD,  16'd1,     CMD_SAMPLE, LV_00, 1'b0, '{32'd0, EV_NONE}},
        '{ROW_WRITE, REG_FAST_THRESHOLD, 16'hFFFF,  CMD_SAMPLE, LV_00, 1'b0, '{32'd0, EV_NONE}},
        '{ROW_WRITE, REG_MID_STEP,       16'hAB00,  CMD_SAMPLE, LV_00, 1'b0, '{32'd0, EV_NONE}},
        '{ROW_WRITE, REG_FAST_STEP,      16'h12FF,  CMD_SAMPLE, LV_00, 1'b0, '{32'd0, EV_NONE}},
        // One tick leaves a window of 1, which selects the zero mid step.
        '{ROW_ITEM, '0, '0, CMD_SAMPLE, LV_11, 1'b0, '{32'd0, EV_NONE}},
        '{ROW_ITEM, '0, '0, CMD_SAMPLE, LV_01, 1'b0, '{32'd0, EV_NONE}},
        '{ROW_ITEM, '0, '0, CMD_TICK,   LV_00, 1'b0, '{32'd0, EV_NONE}},
        '{ROW_ITEM, '0, '0, CMD_SAMPLE, LV_11, 1'b1, '{32'd0, EV_UP}},
        // Three ticks drain a window of 2 and must stop at zero: step of one.
        '{ROW_ITEM, '0, '0, CMD_SAMPLE, LV_10, 1'b0, '{32'd0, EV_NONE}},
        '{ROW_ITEM, '0, '0, CMD_TICK,   LV_01, 1'b0, '{32'd0, EV_NONE}},
        '{ROW_ITEM, '0, '0, CMD_TICK,   LV_10, 1'b0, '{32'd0, EV_NONE}},
        '{ROW_ITEM, '0, '0, CMD_TICK,   LV_11, 1'b0, '{32'd0, EV_NONE}},
        '{ROW_ITEM, '0, '0, CMD_SAMPLE, LV_11, 1'b1, '{32'hFFFF_FFFF, EV_DOWN}},
        // Fast threshold below the mid one: the fast test still wins.
        '{ROW_WRITE, REG_FAST_THRESHOLD, 16'd0,     CMD_SAMPLE, LV_00, 1'b0, '{32'd0, EV_NONE}},
        '{ROW_ITEM, '0, '0, CMD_SAMPLE, LV_01, 1'b0, '{32'd0, EV_NONE}},
        '{ROW_ITEM, '0, '0, CMD_SAMPLE, LV_11, 1'b1, '{32'h0000_00FE, EV_UP}}
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Works out the result of one item and advances the predictor state.
    // The step size is chosen up front. The window changes only on ticks and
    // on samples taken while idle, and no detent completes in either case.
    function automatic count_rec_t predict_detent(input logic command,
                                                  input logic [1:0] levels);
        count_rec_t       res;
        logic [POS_W-1:0] step;
        res.step_event = EV_NONE;
        if (speed_window >= dec_cfg.fast_threshold)
            step = POS_W'(dec_cfg.fast_step);
        else if (speed_window >= dec_cfg.mid_threshold)
            step = POS_W'(dec_cfg.mid_step);
        else
            step = POS_W'(1);
        if (command == CMD_TICK)
        begin
            if (speed_window != '0)
                speed_window = speed_window - 1'b1;
        end
        else
        begin
            case (dec_phase)
                PH_IDLE:
                begin
                    speed_window = dec_cfg.window_reload;
                    if (levels == LV_01)
                        dec_phase = PH_01;
                    else if (levels == LV_10)
                        dec_phase = PH_10;
                end
                PH_01:
                begin
                    if (levels == LV_00)
                        dec_phase = PH_00;
                    else if (levels == LV_11)
                    begin
                        dec_phase      = PH_IDLE;
                        pos_count      = pos_count + step;
                        res.step_event = EV_UP;
                    end
                end
                PH_00:
                begin
                    if (levels == LV_10)
                        dec_phase = PH_10;
                    else if (levels == LV_01)
                        dec_phase = PH_01;
                end
                default:
                begin
                    if (levels == LV_11)
                    begin
                        dec_phase      = PH_IDLE;
                        pos_count      = pos_count - step;
                        res.step_event = EV_DOWN;
                    end
                    else if (levels == LV_00)
                        dec_phase = PH_00;
                end
            endcase
        end
        res.position = pos_count;
        return res;
    endfunction

    // Offers one item after a random gap and waits for its transfer. The
    // expected result is queued at the edge where the transfer happens. Valid
    // stays high afterwards, so back-to-back items keep it up without a dip.
    task automatic send_item(input logic command, input logic [1:0] levels,
                             input bit typed = 1'b0, input count_rec_t want = '0);
        int         gap;
        count_rec_t res;
        gap = (no_idle || sender_calm) ? 0 : $urandom_range(0, IDLE_MAX);
        @(negedge clk);
        if (gap > 0)
        begin
            items_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        items_ch.valid   <= 1'b1;
        items_ch.command <= command;
        items_ch.level_a <= levels[1];
        items_ch.level_b <= levels[0];
        do @(posedge clk); while (items_ch.ready !== 1'b1);
        res = predict_detent(command, levels);
        awaited_counts.push_back(typed ? want : res);
        items_sent++;
        if (command == CMD_TICK)
            ticks_sent++;
        if (res.step_event == EV_UP)
            ups_seen++;
        else if (res.step_event == EV_DOWN)
            downs_seen++;
    endtask

    // Stops offering items and waits until every owed result has arrived.
    // Each item produces exactly one result, so the decoder is idle then.
    task automatic drain();
        @(negedge clk);
        items_ch.valid <= 1'b0;
        while (awaited_counts.size() != 0)
            @(posedge clk);
    endtask

    // Writes one register and mirrors the write into the predictor.
    task automatic cfg_write(input logic [INDEX_W-1:0] index, input logic [CFG_W-1:0] data);
        @(negedge clk);
        write_en   <= 1'b1;
        reg_index  <= index;
        write_data <= data;
        case (index)
            REG_WINDOW_RELOAD:  dec_cfg.window_reload  = data[WIN_W-1:0];
            REG_MID_THRESHOLD:  dec_cfg.mid_threshold  = data[WIN_W-1:0];
            REG_FAST_THRESHOLD: dec_cfg.fast_threshold = data[WIN_W-1:0];
            REG_MID_STEP:       dec_cfg.mid_step       = data[STEP_W-1:0];
            REG_FAST_STEP:      dec_cfg.fast_step      = data[STEP_W-1:0];
            default: ;
        endcase
        writes_done++;
        @(negedge clk);
        write_en <= 1'b0;
    endtask

    // Thresholds mostly fall near the reload value, so that a few ticks move
    // the window across them.
    function automatic logic [WIN_W-1:0] draw_threshold(input logic [WIN_W-1:0] reload);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return WIN_W'($urandom);
            default: return WIN_W'($urandom_range(0, int'(reload) + 2));
        endcase
    endfunction

    // A zero step lies outside the documented range but must still work.
    function automatic logic [STEP_W-1:0] draw_step();
        case ($urandom_range(0, 9))
            0:       return STEP_W'(1);
            1:       return '1;
            2:       return '0;
            default: return STEP_W'($urandom_range(1, 255));
        endcase
    endfunction

    // Loads a new setting for a phase. The first two are the extremes.
    // Writes to the unused indexes must have no effect.
    task automatic apply_setting(input int which);
        logic [WIN_W-1:0]  reload;
        logic [WIN_W-1:0]  mid_thr;
        logic [WIN_W-1:0]  fast_thr;
        logic [STEP_W-1:0] mid_stp;
        logic [STEP_W-1:0] fast_stp;
        case (which)
            0:
            begin
                reload   = '1;
                mid_thr  = '1;
                fast_thr = '1;
                mid_stp  = STEP_W'(1);
                fast_stp = '1;
            end
            1:
            begin
                reload   = '0;
                mid_thr  = '0;
                fast_thr = '0;
                mid_stp  = '1;
                fast_stp = STEP_W'(1);
            end
            default:
            begin
                case ($urandom_range(0, 9))
                    0:       reload = '0;
                    1:       reload = '1;
                    default: reload = WIN_W'($urandom_range(1, 40));
                endcase
                mid_thr  = draw_threshold(reload);
                fast_thr = draw_threshold(reload);
                mid_stp  = draw_step();
                fast_stp = draw_step();
            end
        endcase
        cfg_write(REG_WINDOW_RELOAD, reload);
        cfg_write(REG_MID_THRESHOLD, mid_thr);
        cfg_write(REG_FAST_THRESHOLD, fast_thr);
        cfg_write(REG_MID_STEP, {STEP_W'($urandom), mid_stp});
        cfg_write(REG_FAST_STEP, {STEP_W'($urandom), fast_stp});
        for (int i = int'(REG_FAST_STEP) + 1; i < (1 << INDEX_W); i++)
            cfg_write(INDEX_W'(i), CFG_W'($urandom));
        settings_used++;
    endtask

    // One random gesture. Most gestures are complete detents, either up or
    // down, over the short or the long path. Ticks in between move the window
    // before the step is chosen. A bounce now and then steps back one level
    // and forward again, which can also complete a detent in the other
    // direction. The rest are runs of ticks and pure noise.
    task automatic send_gesture();
        logic [1:0] path [$];
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            case ($urandom_range(0, 3))
                0:       path = '{LV_11, LV_01, LV_11};
                1:       path = '{LV_11, LV_10, LV_00, LV_01, LV_11};
                2:       path = '{LV_11, LV_10, LV_11};
                default: path = '{LV_11, LV_01, LV_00, LV_10, LV_11};
            endcase
            foreach (path[i])
            begin
                send_item(CMD_SAMPLE, path[i]);
                if (i > 0 && $urandom_range(0, 9) == 0)
                begin
                    send_item(CMD_SAMPLE, path[i-1]);
                    send_item(CMD_SAMPLE, path[i]);
                end
                if ($urandom_range(0, 9) < 4)
                    repeat ($urandom_range(1, 3)) send_item(CMD_TICK, 2'($urandom));
            end
        end
        else if (pick < 85)
            repeat ($urandom_range(1, 12)) send_item(CMD_TICK, 2'($urandom));
        else
            send_item(1'($urandom), 2'($urandom));
    endtask

    // Main sequence: reset, the scripted run, then the random phases.
    initial
    begin
        int  target;
        int  halfway;
        bit  paused;
        rst_n            = 1'b0;
        write_en         = 1'b0;
        reg_index        = '0;
        write_data       = '0;
        items_ch.valid   = 1'b0;
        items_ch.command = CMD_SAMPLE;
        items_ch.level_a = 1'b0;
        items_ch.level_b = 1'b0;
        dec_cfg      = '{RST_WINDOW_RELOAD, RST_MID_THRESHOLD, RST_FAST_THRESHOLD,
                         RST_MID_STEP, RST_FAST_STEP};
        dec_phase    = PH_IDLE;
        speed_window = '0;
        pos_count    = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Register writes in the script wait until the decoder is idle.
        foreach (script[i])
        begin
            if (script[i].kind == ROW_WRITE)
            begin
                drain();
                cfg_write(script[i].index, script[i].data);
            end
            else
                send_item(script[i].command, script[i].levels, script[i].typed,
                          script[i].want);
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain();
            apply_setting(p);
            no_idle = (p == 4);
            target  = items_sent + PHASE_ITEMS;
            halfway = items_sent + PHASE_ITEMS / 2;
            paused  = 1'b0;
            // Back-pressure phase: the result side holds off for a long time
            // while items keep coming with no gaps, so the input stalls.
            if (p == 2)
            begin
                hold_request = 1'b1;
                sender_calm  = 1'b1;
                while (items_sent < target - PHASE_ITEMS + BURST_ITEMS)
                    send_gesture();
                sender_calm = 1'b0;
            end
            while (items_sent < target)
            begin
                send_gesture();
                if (!paused && items_sent >= halfway)
                begin
                    drain();
                    paused = 1'b1;
                end
            end
        end

        drain();
        no_idle = 1'b0;
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("tb: %0d item transfers (%0d timer ticks) gave %0d up and %0d down detents",
                 items_sent, ticks_sent, ups_seen, downs_seen);
        $display("tb: %0d register settings over %0d register writes in %0d cycles",
                 settings_used, writes_done, cycle_count);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // Result side: ready drops for a random number of cycles before each
    // transfer, plus the long hold-off when one is requested.
    initial
    begin
        int stall;
        results_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
            if (hold_request)
            begin
                stall        = stall + HOLD_CYCLES;
                hold_request = 1'b0;
            end
            @(negedge clk);
            if (stall > 0)
            begin
                results_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            results_ch.ready <= 1'b1;
            do @(posedge clk); while (results_ch.valid !== 1'b1);
        end
    end

    // Every result transfer is matched against the oldest owed result.
    always @(posedge clk)
    begin
        count_rec_t want;
        if (rst_n === 1'b1 && results_ch.valid === 1'b1 && results_ch.ready === 1'b1)
        begin
            if (awaited_counts.size() == 0)
            begin
                mismatches++;
                $display("%0t tb: result with nothing owed, position %0h, event %0d",
                         $time, results_ch.position, results_ch.step_event);
            end
            else
            begin
                want = awaited_counts.pop_front();
                if (results_ch.position !== want.position)
                begin
                    mismatches++;
                    $display("%0t tb: position mismatch, expected %0h, actual %0h",
                             $time, want.position, results_ch.position);
                end
                if (results_ch.step_event !== want.step_event)
                begin
                    mismatches++;
                    $display("%0t tb: step event mismatch, expected %0d, actual %0d",
                             $time, want.step_event, results_ch.step_event);
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: timeout after %0d cycles, %0d results still owed",
                 cycle_count, awaited_counts.size());
        $display("tb: FAIL");
        $finish;
    end

endmodule
